FILE: src/gola_pkg.sv
// Shared constants, types and the control-word program of the granular resampler.
`timescale 1ns / 1ps

package gola_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAX_GRAIN   = 2048;
    localparam int ADDR_W      = $clog2(MAX_GRAIN);
    localparam int GRAIN_W     = 12;
    localparam int OVL_W       = 11;
    localparam int SCALE_W     = 13;
    localparam int BLK_W       = 20;
    localparam int SCALE_SHIFT = 12;
    localparam int SCALE_ONE   = 1 << SCALE_SHIFT;
    localparam int PROD_W      = ADDR_W + SCALE_W;
    localparam int ACC_W       = SAMPLE_W + ADDR_W;
    localparam int REM_W       = ADDR_W;
    localparam int DIVR_W      = GRAIN_W;
    localparam int DIVC_W      = $clog2(BLK_W);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_IDX_W-1:0] REG_GRAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK   = 2'd3;

    typedef enum logic [3:0] {
        ST_WAIT       = 4'd0,
        ST_WRITE      = 4'd1,
        ST_DIV_INIT   = 4'd2,
        ST_DIV_STEP   = 4'd3,
        ST_DIV_DONE   = 4'd4,
        ST_GRAIN_INIT = 4'd5,
        ST_MUL        = 4'd6,
        ST_ADDR       = 4'd7,
        ST_ACC        = 4'd8,
        ST_EMIT       = 4'd9
    } step_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ACCEPT   = 3'd1,
        C_CLEAN    = 3'd2,
        C_DIV_MORE = 3'd3,
        C_MORE     = 3'd4,
        C_OUT_FREE = 3'd5
    } cond_t;

    typedef struct packed {
        logic  tready;
        logic  hist_wr;
        logic  trk_upd;
        logic  div_init;
        logic  div_step;
        logic  div_done;
        logic  grain_init;
        logic  mul;
        logic  addr;
        logic  acc;
        logic  emit;
        logic  hold;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        begin
            w        = '0;
            w.cond   = C_NEVER;
            w.target = ST_WAIT;
            case (step)
                ST_WAIT: begin
                    w.tready = 1'b1;
                    w.hold   = 1'b1;
                    w.cond   = C_ACCEPT;
                    w.target = ST_WRITE;
                end
                ST_WRITE: begin
                    w.hist_wr = 1'b1;
                    w.trk_upd = 1'b1;
                    w.cond    = C_CLEAN;
                    w.target  = ST_GRAIN_INIT;
                end
                ST_DIV_INIT: begin
                    w.div_init = 1'b1;
                end
                ST_DIV_STEP: begin
                    w.div_step = 1'b1;
                    w.cond     = C_DIV_MORE;
                    w.target   = ST_DIV_STEP;
                end
                ST_DIV_DONE: begin
                    w.div_done = 1'b1;
                end
                ST_GRAIN_INIT: begin
                    w.grain_init = 1'b1;
                end
                ST_MUL: begin
                    w.mul = 1'b1;
                end
                ST_ADDR: begin
                    w.addr = 1'b1;
                end
                ST_ACC: begin
                    w.acc    = 1'b1;
                    w.cond   = C_MORE;
                    w.target = ST_MUL;
                end
                ST_EMIT: begin
                    w.emit   = 1'b1;
                    w.hold   = 1'b1;
                    w.cond   = C_OUT_FREE;
                    w.target = ST_WAIT;
                end
                default: begin
                    w.cond   = C_NEVER;
                    w.target = ST_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

FILE: src/gola_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module gola_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/granular_overlap_add_resampler.sv
// Top level of the granular overlap-add resampler with its microcoded sequencer.
//
// Usage:
//   s_ channel: one signed 16-bit sample per word; m_ channel: one saturated
//   signed 16-bit sample per input word, in input order. Configuration
//   (grain length, overlap, index scale, block length) is written through
//   cfg_we / cfg_index / cfg_data while the block is idle.
//   Each word runs a short control program: accept, history write, one
//   three-step multiply/read/accumulate pass per grain covering the current
//   frame position, then output load. With k covering grains (at most
//   ceil(grain / hop)) the sequencer runs k such passes; ready returns in the
//   same cycle as the result appears, so a new word is not accepted while
//   the previous one is being worked. The first word after reset or after
//   any configuration write also passes through the serial remainder unit,
//   which first locates the current grain.
//   Reset clears the frame position, loads the register defaults and empties
//   the output register. When the receiver stalls, the finished word waits in
//   the output register; the next input word is still accepted and worked,
//   and the sequencer holds at output load until the register frees.
`timescale 1ns / 1ps

module granular_overlap_add_resampler import gola_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    step_t                     pc_reg, pc_next;
    logic [GRAIN_W-1:0]        grain_reg, grain_next;
    logic [OVL_W-1:0]          ovl_reg, ovl_next;
    logic [SCALE_W-1:0]        scale_reg, scale_next;
    logic [BLK_W-1:0]          blk_reg, blk_next;
    logic [BLK_W-1:0]          fp_reg, fp_next;
    logic [BLK_W-1:0]          p_reg, p_next;
    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic [BLK_W-1:0]          base_reg, base_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic                      dirty_reg, dirty_next;
    logic [DIVC_W-1:0]         divc_reg, divc_next;
    logic [DIVR_W-1:0]         divr_reg, divr_next;
    logic [BLK_W-1:0]          scur_reg, scur_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic                      use_reg, use_next;
    logic                      more_reg, more_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      mvalid_reg, mvalid_next;
    logic [SAMPLE_W-1:0]       mdata_reg, mdata_next;

    ucode_t                    uc;
    logic                      cond_true;
    logic                      out_free;
    logic [GRAIN_W-1:0]        g_eff, ov_eff, hop;
    logic [SCALE_W-1:0]        sc_eff;
    logic [BLK_W-1:0]          blen_eff;
    logic [DIVR_W:0]           div_t;
    logic [DIVR_W-1:0]         div_r_step;
    logic [ADDR_W-1:0]         diff;
    logic [BLK_W:0]            span_end;
    logic                      use_c, more_c, roll;
    logic [ADDR_W-1:0]         src_addr;
    logic [SAMPLE_W-1:0]       rd_data;
    logic [BLK_W:0]            p_inc;
    logic [BLK_W-1:0]          fp_wrap;
    logic                      sat_hi, sat_lo;
    logic [SAMPLE_W-1:0]       sat_val;

    always_comb begin
        g_eff = grain_reg;
        if (grain_reg < GRAIN_W'(2)) begin
            g_eff = GRAIN_W'(2);
        end else if (grain_reg > GRAIN_W'(MAX_GRAIN)) begin
            g_eff = GRAIN_W'(MAX_GRAIN);
        end
        ov_eff = (GRAIN_W'(ovl_reg) >= g_eff) ? g_eff - GRAIN_W'(1) : GRAIN_W'(ovl_reg);
        hop    = g_eff - ov_eff;
        sc_eff = scale_reg;
        if (scale_reg == '0) begin
            sc_eff = SCALE_W'(1);
        end else if (scale_reg > SCALE_W'(SCALE_ONE)) begin
            sc_eff = SCALE_W'(SCALE_ONE);
        end
        blen_eff = (blk_reg == '0) ? BLK_W'(1) : blk_reg;
    end

    always_comb begin
        div_t      = {divr_reg, p_reg[divc_reg]};
        div_r_step = (div_t >= (DIVR_W+1)'(hop)) ? DIVR_W'(div_t - (DIVR_W+1)'(hop))
                                                 : div_t[DIVR_W-1:0];
        diff       = ADDR_W'(p_reg - scur_reg);
        span_end   = {1'b0, scur_reg} + (BLK_W+1)'(g_eff);
        use_c      = span_end <= {1'b0, blen_eff};
        more_c     = (span_end > ({1'b0, p_reg} + (BLK_W+1)'(hop)))
                     && (scur_reg >= BLK_W'(hop));
        roll       = (GRAIN_W'(rem_reg) + GRAIN_W'(1)) >= hop;
        src_addr   = scur_reg[ADDR_W-1:0] + prod_reg[SCALE_SHIFT+ADDR_W-1:SCALE_SHIFT];
        p_inc      = {1'b0, p_reg} + (BLK_W+1)'(1);
        fp_wrap    = (p_inc >= {1'b0, blen_eff}) ? '0 : p_inc[BLK_W-1:0];
        sat_hi     = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:SAMPLE_W-1]);
        sat_lo     = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:SAMPLE_W-1]);
        if (sat_hi) begin
            sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (sat_lo) begin
            sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat_val = acc_reg[SAMPLE_W-1:0];
        end
    end

    assign uc       = ucode_rom(pc_reg);
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        case (uc.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ACCEPT:   cond_true = s_tvalid;
            C_CLEAN:    cond_true = !dirty_reg;
            C_DIV_MORE: cond_true = divc_reg != '0;
            C_MORE:     cond_true = more_reg;
            C_OUT_FREE: cond_true = out_free;
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_true) begin
            pc_next = uc.target;
        end else if (uc.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = step_t'(pc_reg + 4'd1);
        end
    end

    always_comb begin
        grain_next  = grain_reg;
        ovl_next    = ovl_reg;
        scale_next  = scale_reg;
        blk_next    = blk_reg;
        fp_next     = fp_reg;
        p_next      = p_reg;
        sample_next = sample_reg;
        base_next   = base_reg;
        rem_next    = rem_reg;
        dirty_next  = dirty_reg;
        divc_next   = divc_reg;
        divr_next   = divr_reg;
        scur_next   = scur_reg;
        prod_next   = prod_reg;
        use_next    = use_reg;
        more_next   = more_reg;
        acc_next    = acc_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        if (uc.tready && s_tvalid) begin
            p_next      = (fp_reg >= blen_eff) ? '0 : fp_reg;
            sample_next = s_tdata;
        end

        if (uc.trk_upd) begin
            if (p_reg == '0) begin
                base_next = '0;
                rem_next  = '0;
            end else if (roll) begin
                base_next = base_reg + BLK_W'(rem_reg) + BLK_W'(1);
                rem_next  = '0;
            end else begin
                rem_next = rem_reg + REM_W'(1);
            end
        end

        if (uc.div_init) begin
            divc_next  = DIVC_W'(BLK_W - 1);
            divr_next  = '0;
            dirty_next = 1'b0;
        end
        if (uc.div_step) begin
            divr_next = div_r_step;
            divc_next = divc_reg - DIVC_W'(1);
        end
        if (uc.div_done) begin
            rem_next  = divr_reg[REM_W-1:0];
            base_next = p_reg - BLK_W'(divr_reg[REM_W-1:0]);
        end

        if (uc.grain_init) begin
            scur_next = base_reg;
            acc_next  = '0;
        end
        if (uc.mul) begin
            prod_next = PROD_W'(diff) * PROD_W'(sc_eff);
            use_next  = use_c;
        end
        if (uc.addr) begin
            more_next = more_c;
            if (more_c) begin
                scur_next = scur_reg - BLK_W'(hop);
            end
        end
        if (uc.acc && use_reg) begin
            acc_next = acc_reg + {{(ACC_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
        end

        if (uc.emit && out_free) begin
            mvalid_next = 1'b1;
            mdata_next  = sat_val;
            fp_next     = fp_wrap;
        end

        if (cfg_we) begin
            dirty_next = 1'b1;
            case (cfg_index)
                REG_GRAIN:   grain_next = cfg_data[GRAIN_W-1:0];
                REG_OVERLAP: ovl_next   = cfg_data[OVL_W-1:0];
                REG_SCALE:   scale_next = cfg_data[SCALE_W-1:0];
                REG_BLOCK:   blk_next   = cfg_data[BLK_W-1:0];
                default:     dirty_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= ST_WAIT;
            grain_reg  <= GRAIN_W'(1024);
            ovl_reg    <= OVL_W'(512);
            scale_reg  <= SCALE_W'(2048);
            blk_reg    <= BLK_W'(4096);
            fp_reg     <= '0;
            base_reg   <= '0;
            rem_reg    <= '0;
            dirty_reg  <= 1'b1;
            divc_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            pc_reg     <= pc_next;
            grain_reg  <= grain_next;
            ovl_reg    <= ovl_next;
            scale_reg  <= scale_next;
            blk_reg    <= blk_next;
            fp_reg     <= fp_next;
            base_reg   <= base_next;
            rem_reg    <= rem_next;
            dirty_reg  <= dirty_next;
            divc_reg   <= divc_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg      <= p_next;
        sample_reg <= sample_next;
        divr_reg   <= divr_next;
        scur_reg   <= scur_next;
        prod_reg   <= prod_next;
        use_reg    <= use_next;
        more_reg   <= more_next;
        acc_reg    <= acc_next;
        mdata_reg  <= mdata_next;
    end

    gola_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_GRAIN)
    ) u_hist (
        .aclk  (aclk),
        .we    (uc.hist_wr),
        .waddr (p_reg[ADDR_W-1:0]),
        .wdata (sample_reg),
        .raddr (src_addr),
        .rdata (rd_data)
    );

    assign s_tready = uc.tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    a_accept_to_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (pc_reg == ST_WRITE))
        else $error("accepted word did not advance to history write");

    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(pc_reg) == ST_EMIT))
        else $error("output loaded outside output step");

    a_tracker: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == ST_MUL) |-> (BLK_W'(base_reg + BLK_W'(rem_reg)) == p_reg))
        else $error("grain tracker out of step with frame position");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.emit && out_free) |=> (fp_reg < $past(blen_eff)))
        else $error("frame position past block length");

endmodule
